/* rtl/ebe_pkg.sv */
// Shared types and codes for the eraser button emulation block.
package ebe_pkg;

	localparam int TIMER_W = 20;
	localparam int DELAY_W = 20;
	localparam int CODE_W  = 10;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(30 * 1000);
	localparam logic [CODE_W-1:0]  CODE_RESET  = CODE_W'(331);

	// Configuration register indexes.
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_DELAY  = 2'd1;
	localparam logic [1:0] REG_CODE   = 2'd2;

	// Result kinds.
	localparam logic [1:0] K_CUR    = 2'd0;
	localparam logic [1:0] K_STORED = 2'd1;
	localparam logic [1:0] K_PASS   = 2'd2;
	localparam logic [1:0] K_DROP   = 2'd3;

	// Appended pen proximity and button actions.
	localparam logic [1:0] PEN_NONE    = 2'd0;
	localparam logic [1:0] PEN_IN_ACT  = 2'd1;
	localparam logic [1:0] PEN_OUT_ACT = 2'd2;
	localparam logic [1:0] BTN_NONE    = 2'd0;
	localparam logic [1:0] BTN_PRESS   = 2'd1;
	localparam logic [1:0] BTN_RELEASE = 2'd2;

	typedef struct packed {
		logic               enable;
		logic [DELAY_W-1:0] delay;
		logic [CODE_W-1:0]  code;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] pen;
		logic [1:0] btn;
		logic       strip;
	} res_t;

	// All results of one input item, handed from the front to the back.
	typedef struct packed {
		res_t [2:0]        res;
		logic [1:0]        cnt;
		logic              bad;
		logic [CODE_W-1:0] code;
	} bundle_t;

endpackage

/* rtl/ebe_front.sv */
// Front end: accepts items, runs the emulation state machine and builds result bundles.
module ebe_front
	import ebe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         q_full,
	output logic         push,
	output bundle_t      push_data
);

	localparam logic [1:0] ST_NEUTRAL  = 2'd0;
	localparam logic [1:0] ST_PENDING  = 2'd1;
	localparam logic [1:0] ST_HELD     = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	localparam logic [2:0] EV_PEN_IN     = 3'd0;
	localparam logic [2:0] EV_PEN_OUT    = 3'd1;
	localparam logic [2:0] EV_ERASER_IN  = 3'd2;
	localparam logic [2:0] EV_ERASER_OUT = 3'd3;
	localparam logic [2:0] EV_TIMEOUT    = 3'd4;

	typedef struct packed {
		logic [1:0] st;
		logic [1:0] n;
		res_t       em0;
		res_t       em1;
		logic       drop;
		logic       bad;
		logic       arm;
		logic       disarm;
	} hres_t;

	typedef struct packed {
		res_t [2:0] r;
		logic [1:0] n;
	} acc_t;

	function automatic res_t mk(logic [1:0] kind, logic [1:0] pen, logic [1:0] btn,
			logic strip);
		res_t r;
		r.kind  = kind;
		r.pen   = pen;
		r.btn   = btn;
		r.strip = strip;
		return r;
	endfunction

	function automatic hres_t handle(logic [1:0] st, logic [2:0] ev);
		hres_t h;
		h = '0;
		h.st = st;
		unique case (st)
			ST_NEUTRAL: begin
				if (ev == EV_PEN_OUT) begin
					h.arm  = 1'b1;
					h.st   = ST_PENDING;
					h.drop = 1'b1;
				end else if (ev == EV_ERASER_IN) begin
					h.em0  = mk(K_CUR, PEN_IN_ACT, BTN_PRESS, 1'b1);
					h.n    = 2'd1;
					h.st   = ST_HELD;
					h.drop = 1'b1;
				end else if (ev == EV_ERASER_OUT) begin
					h.bad = 1'b1;
				end
			end
			ST_PENDING: begin
				if (ev == EV_PEN_IN) begin
					h.disarm = 1'b1;
					h.st     = ST_NEUTRAL;
				end else if (ev == EV_ERASER_IN) begin
					h.disarm = 1'b1;
					h.em0    = mk(K_CUR, PEN_NONE, BTN_PRESS, 1'b1);
					h.n      = 2'd1;
					h.st     = ST_HELD;
					h.drop   = 1'b1;
				end else if (ev == EV_TIMEOUT) begin
					h.st  = ST_NEUTRAL;
					h.em0 = mk(K_STORED, PEN_OUT_ACT, BTN_NONE, 1'b0);
					h.n   = 2'd1;
				end else begin
					h.bad = 1'b1;
				end
			end
			ST_HELD: begin
				if (ev == EV_ERASER_OUT) begin
					h.em0  = mk(K_STORED, PEN_NONE, BTN_RELEASE, 1'b1);
					h.n    = 2'd1;
					h.st   = ST_RELEASED;
					h.arm  = 1'b1;
					h.drop = 1'b1;
				end else begin
					h.bad = 1'b1;
				end
			end
			ST_RELEASED: begin
				if (ev == EV_PEN_IN) begin
					h.disarm = 1'b1;
					h.em0    = mk(K_CUR, PEN_NONE, BTN_NONE, 1'b0);
					h.n      = 2'd1;
					h.st     = ST_NEUTRAL;
					h.drop   = 1'b1;
				end else if (ev == EV_TIMEOUT) begin
					h.em0 = mk(K_STORED, PEN_NONE, BTN_RELEASE, 1'b1);
					h.em1 = mk(K_STORED, PEN_OUT_ACT, BTN_NONE, 1'b0);
					h.n   = 2'd2;
					h.st  = ST_NEUTRAL;
				end else if (ev != EV_ERASER_IN) begin
					h.bad = 1'b1;
				end
			end
		endcase
		return h;
	endfunction

	function automatic acc_t append(acc_t a, res_t r);
		acc_t b;
		b = a;
		if (a.n != 2'd3) begin
			b.r[a.n] = r;
			b.n = a.n + 2'd1;
		end
		return b;
	endfunction

	logic [1:0]         st_q;
	logic               pen_q;
	logic               eraser_q;
	logic               armed_q;
	logic [TIMER_W-1:0] left_q;

	logic [1:0]         st_d;
	logic               pen_d;
	logic               eraser_d;
	logic               armed_d;
	logic [TIMER_W-1:0] left_d;
	logic [TIMER_W-1:0] arm_val;
	acc_t               acc;
	logic               bad;
	logic               accept;

	always_comb begin
		arm_val = TIMER_W'(cfg.delay);
		if (arm_val == '0) begin
			arm_val = TIMER_W'(1);
		end
	end

	always_comb begin
		hres_t      h1;
		hres_t      h2;
		logic       pt;
		logic       et;
		logic [2:0] pev;
		logic [2:0] eev;
		logic       drop;

		st_d     = st_q;
		pen_d    = pen_q;
		eraser_d = eraser_q;
		armed_d  = armed_q;
		left_d   = left_q;
		acc      = '0;
		bad      = 1'b0;
		drop     = 1'b0;
		h1       = '0;
		h2       = '0;
		pt       = s_tdata[0];
		et       = s_tdata[2];
		pev      = EV_PEN_IN;
		eev      = EV_ERASER_IN;

		if (s_tuser[0]) begin
			// Timer tick, independent of the enable bit.
			if (armed_q) begin
				if (left_q <= TIMER_W'(1)) begin
					armed_d = 1'b0;
					left_d  = '0;
					h1 = handle(st_q, EV_TIMEOUT);
					st_d = h1.st;
					bad  = h1.bad;
					if (h1.n != 2'd0) begin
						acc = append(acc, h1.em0);
					end
					if (h1.n == 2'd2) begin
						acc = append(acc, h1.em1);
					end
				end else begin
					left_d = left_q - TIMER_W'(1);
				end
			end
		end else if (!cfg.enable) begin
			acc = append(acc, mk(K_PASS, PEN_NONE, BTN_NONE, 1'b0));
		end else begin
			if (pt) begin
				pen_d = s_tdata[1];
			end
			if (et) begin
				eraser_d = s_tdata[3];
			end
			pev = pen_d ? EV_PEN_IN : EV_PEN_OUT;
			eev = eraser_d ? EV_ERASER_IN : EV_ERASER_OUT;

			// With both tools toggled, the tool that leaves goes first.
			if (pt && et) begin
				h1 = handle(st_q, pen_d ? eev : pev);
				h2 = handle(h1.st, pen_d ? pev : eev);
			end else if (et) begin
				h2 = handle(st_q, eev);
			end else if (pt) begin
				h2 = handle(st_q, pev);
			end else begin
				h2 = '0;
				h2.st = st_q;
			end

			if (h1.arm) begin
				armed_d = 1'b1;
				left_d  = arm_val;
			end
			if (h1.disarm) begin
				armed_d = 1'b0;
				left_d  = '0;
			end
			if (h2.arm) begin
				armed_d = 1'b1;
				left_d  = arm_val;
			end
			if (h2.disarm) begin
				armed_d = 1'b0;
				left_d  = '0;
			end
			if (h1.n != 2'd0) begin
				acc = append(acc, h1.em0);
			end
			if (h2.n != 2'd0) begin
				acc = append(acc, h2.em0);
			end
			st_d = h2.st;
			bad  = h1.bad | h2.bad;
			drop = h2.drop;
			acc  = append(acc, mk(drop ? K_DROP : K_PASS, PEN_NONE, BTN_NONE, 1'b0));
		end
	end

	assign s_tready       = !q_full;
	assign accept         = s_tvalid && s_tready;
	assign push           = accept && (acc.n != 2'd0);
	assign push_data.res  = acc.r;
	assign push_data.cnt  = acc.n;
	assign push_data.bad  = bad;
	assign push_data.code = cfg.code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_NEUTRAL;
			pen_q    <= 1'b0;
			eraser_q <= 1'b0;
			armed_q  <= 1'b0;
			left_q   <= '0;
		end else if (accept) begin
			st_q     <= st_d;
			pen_q    <= pen_d;
			eraser_q <= eraser_d;
			armed_q  <= armed_d;
			left_q   <= left_d;
		end
	end

endmodule

/* rtl/ebe_queue.sv */
// Two-entry queue of result bundles between the front and the back.
module ebe_queue
	import ebe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output bundle_t head
);

	bundle_t    mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/ebe_back.sv */
// Back end: walks the results of the head bundle and drives them one beat at a time.
module ebe_back
	import ebe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  bundle_t     head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       is_last;
	res_t       cur;

	assign load    = head_valid && (!valid_q || m_tready);
	assign cur     = head.res[idx_q];
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tuser <= cur.kind;
			m_tlast <= is_last;
			m_tdata <= {head.bad, cur.strip ? head.code : {CODE_W{1'b0}}, cur.strip, cur.btn,
				cur.pen};
		end
	end

	assign m_tvalid = valid_q;

endmodule

/* rtl/eraser_button_emulation.sv */
// Top level of the eraser button emulation block: configuration registers and the two halves.
//
// The block accepts one input beat per cycle while its two-entry result queue has room; the
// front end updates the emulation state and the timer in the accepting cycle. Each input
// gives zero to three result beats, and the back end sends one result beat per cycle from
// its output register while the receiver is ready. Configuration is taken in the cycle of
// the write and should only change while no results are outstanding.
module eraser_button_emulation
	import ebe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [19:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pen toggle, pen value, eraser toggle, eraser value, then zero fill
	input  logic [7:0]   s_tdata,
	// command
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pen_prox_action, button_action, strip_button, button_code_res, invalid_event
	output logic [15:0]  m_tdata,
	// kind
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	cfg_t    cfg_q;
	logic    q_full;
	logic    push;
	bundle_t push_data;
	logic    pop;
	logic    head_valid;
	bundle_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.delay  <= DELAY_RESET;
			cfg_q.code   <= CODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				REG_DELAY:  cfg_q.delay  <= cfg_data[DELAY_W-1:0];
				REG_CODE:   cfg_q.code   <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	ebe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	ebe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ebe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

/* tb/sv/eraser_button_emulation_tb.sv */
// Self-checking testbench for the eraser button emulation block, with its own predictor.
module eraser_button_emulation_tb;
	import ebe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic       CMD_FRAME = 1'b0;
	localparam logic       CMD_TICK  = 1'b1;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		EMU_NEUTRAL, EMU_PENDING, EMU_HELD, EMU_RELEASED
	} emu_state_e;

	typedef enum logic [2:0] {
		PEN_ARRIVES, PEN_LEAVES, ERASER_ARRIVES, ERASER_LEAVES, TIMER_FIRES
	} tool_event_e;

	typedef struct packed {
		logic cmd;
		logic pen_tog;
		logic pen_in;
		logic era_tog;
		logic era_in;
	} stim_t;

	// Hand-written expectation: at most one verdict beat with no appended events.
	typedef struct packed {
		logic       typed;
		logic [1:0] cnt;
		logic [1:0] kind;
		logic       bad;
	} fixed_t;

	typedef struct packed {
		stim_t  s;
		fixed_t f;
	} row_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        pen;
		logic [1:0]        btn;
		logic              strip;
		logic [CODE_W-1:0] code;
		logic              bad;
		logic              last;
	} res_beat_t;

	localparam fixed_t NO_FIX   = '0;
	localparam fixed_t PASS_OK  = '{1'b1, 2'd1, K_PASS, 1'b0};
	localparam fixed_t PASS_BAD = '{1'b1, 2'd1, K_PASS, 1'b1};
	localparam fixed_t NOTHING  = '{1'b1, 2'd0, K_PASS, 1'b0};

	localparam int PLAN_LEN = 26;
	localparam int PLAN_DISABLED = 3;
	localparam row_t PLAN [0:PLAN_LEN-1] = '{
		// Straight after reset: emulation off, the timer never armed.
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b0, 1'b0}, PASS_OK},
		'{'{CMD_FRAME, 1'b1, 1'b1, 1'b0, 1'b0}, PASS_OK},
		'{'{CMD_TICK,  1'b0, 1'b0, 1'b0, 1'b0}, NOTHING},
		// Emulation on, timeout of two ticks, button code 767.
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b0, 1'b0}, PASS_OK},
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b1, 1'b0}, PASS_BAD},
		'{'{CMD_FRAME, 1'b1, 1'b1, 1'b0, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b1, 1'b0, 1'b0, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b1, 1'b0, 1'b0, 1'b0}, PASS_BAD},
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b1, 1'b0}, PASS_BAD},
		'{'{CMD_TICK,  1'b1, 1'b1, 1'b1, 1'b1}, NO_FIX},
		'{'{CMD_TICK,  1'b0, 1'b0, 1'b0, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b1, 1'b1, 1'b0, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b1, 1'b0, 1'b0, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b1, 1'b1}, NO_FIX},
		'{'{CMD_TICK,  1'b0, 1'b0, 1'b0, 1'b0}, NOTHING},
		'{'{CMD_FRAME, 1'b1, 1'b1, 1'b0, 1'b0}, PASS_BAD},
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b1, 1'b1}, PASS_BAD},
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b1, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b1, 1'b1}, NO_FIX},
		'{'{CMD_FRAME, 1'b1, 1'b0, 1'b0, 1'b0}, PASS_BAD},
		'{'{CMD_TICK,  1'b0, 1'b0, 1'b0, 1'b0}, NO_FIX},
		'{'{CMD_TICK,  1'b0, 1'b0, 1'b0, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b0, 1'b0, 1'b1, 1'b1}, NO_FIX},
		// Both tools toggle in one frame: the leaving one goes first.
		'{'{CMD_FRAME, 1'b1, 1'b1, 1'b1, 1'b0}, NO_FIX},
		'{'{CMD_FRAME, 1'b1, 1'b0, 1'b1, 1'b1}, NO_FIX},
		'{'{CMD_FRAME, 1'b1, 1'b0, 1'b1, 1'b0}, NO_FIX}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = REG_ENABLE;
	logic [19:0]         cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic [0:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	fixed_t              cur_fix = NO_FIX;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  mismatches = 0;
	res_beat_t           pending_results[$];

	// Predictor copy of the registers and of the emulation state.
	logic                em_enable = 1'b0;
	logic [DELAY_W-1:0]  em_delay = DELAY_RESET;
	logic [CODE_W-1:0]   em_code = CODE_RESET;
	emu_state_e          em_state = EMU_NEUTRAL;
	logic                em_pen = 1'b0;
	logic                em_eraser = 1'b0;
	logic                em_armed = 1'b0;
	logic [TIMER_W-1:0]  em_left = '0;
	res_beat_t           em_out[3];
	int                  em_count;
	logic                em_bad;

	// The stimulus side tracks where it has moved the tools, to build coherent sequences.
	logic                gen_enable = 1'b0;
	logic                gen_pen = 1'b0;
	logic                gen_eraser = 1'b0;

	eraser_button_emulation u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void add_result(logic [1:0] kind, logic [1:0] pen, logic [1:0] btn,
			logic strip);
		if (em_count < 3) begin
			em_out[em_count] = '{kind, pen, btn, strip, strip ? em_code : '0, 1'b0, 1'b0};
			em_count++;
		end
	endfunction

	function automatic void arm_timeout();
		em_armed = 1'b1;
		em_left = (em_delay == '0) ? TIMER_W'(1) : TIMER_W'(em_delay);
	endfunction

	function automatic void disarm_timeout();
		em_armed = 1'b0;
		em_left = '0;
	endfunction

	// Returns 1 when the current frame is swallowed.
	function automatic logic apply_event(tool_event_e ev);
		case (em_state)
			EMU_NEUTRAL: begin
				if (ev == PEN_LEAVES) begin
					arm_timeout();
					em_state = EMU_PENDING;
					return 1'b1;
				end
				if (ev == ERASER_ARRIVES) begin
					add_result(K_CUR, PEN_IN_ACT, BTN_PRESS, 1'b1);
					em_state = EMU_HELD;
					return 1'b1;
				end
				if (ev == ERASER_LEAVES)
					em_bad = 1'b1;
				return 1'b0;
			end
			EMU_PENDING: begin
				if (ev == PEN_ARRIVES) begin
					disarm_timeout();
					em_state = EMU_NEUTRAL;
				end else if (ev == ERASER_ARRIVES) begin
					disarm_timeout();
					add_result(K_CUR, PEN_NONE, BTN_PRESS, 1'b1);
					em_state = EMU_HELD;
					return 1'b1;
				end else if (ev == TIMER_FIRES) begin
					em_state = EMU_NEUTRAL;
					add_result(K_STORED, PEN_OUT_ACT, BTN_NONE, 1'b0);
				end else begin
					em_bad = 1'b1;
				end
				return 1'b0;
			end
			EMU_HELD: begin
				if (ev == ERASER_LEAVES) begin
					add_result(K_STORED, PEN_NONE, BTN_RELEASE, 1'b1);
					em_state = EMU_RELEASED;
					arm_timeout();
					return 1'b1;
				end
				em_bad = 1'b1;
				return 1'b0;
			end
			default: begin
				if (ev == PEN_ARRIVES) begin
					disarm_timeout();
					add_result(K_CUR, PEN_NONE, BTN_NONE, 1'b0);
					em_state = EMU_NEUTRAL;
					return 1'b1;
				end
				if (ev == TIMER_FIRES) begin
					add_result(K_STORED, PEN_NONE, BTN_RELEASE, 1'b1);
					add_result(K_STORED, PEN_OUT_ACT, BTN_NONE, 1'b0);
					em_state = EMU_NEUTRAL;
				end else if (ev != ERASER_ARRIVES) begin
					em_bad = 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void emulate_item(stim_t it);
		tool_event_e pen_ev, era_ev;
		logic        drop;
		em_count = 0;
		em_bad = 1'b0;
		drop = 1'b0;
		if (it.cmd == CMD_TICK) begin
			if (em_armed) begin
				if (em_left <= 1) begin
					disarm_timeout();
					void'(apply_event(TIMER_FIRES));
				end else begin
					em_left = em_left - 1'b1;
				end
			end
		end else if (!em_enable) begin
			add_result(K_PASS, PEN_NONE, BTN_NONE, 1'b0);
		end else begin
			if (it.pen_tog)
				em_pen = it.pen_in;
			if (it.era_tog)
				em_eraser = it.era_in;
			pen_ev = em_pen ? PEN_ARRIVES : PEN_LEAVES;
			era_ev = em_eraser ? ERASER_ARRIVES : ERASER_LEAVES;
			if (it.pen_tog && it.era_tog) begin
				if (em_pen) begin
					void'(apply_event(era_ev));
					drop = apply_event(pen_ev);
				end else begin
					void'(apply_event(pen_ev));
					drop = apply_event(era_ev);
				end
			end else if (it.era_tog) begin
				drop = apply_event(era_ev);
			end else if (it.pen_tog) begin
				drop = apply_event(pen_ev);
			end
			add_result(drop ? K_DROP : K_PASS, PEN_NONE, BTN_NONE, 1'b0);
		end
		for (int i = 0; i < em_count; i++) begin
			em_out[i].bad = em_bad;
			em_out[i].last = (i == em_count - 1);
		end
	endfunction

	// Input acceptance and result checking share one process so their order is fixed.
	always @(posedge clk) begin : watch
		stim_t     acc;
		res_beat_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				acc = '{s_tuser[0], s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3]};
				emulate_item(acc);
				if (cur_fix.typed) begin
					for (int i = 0; i < cur_fix.cnt; i++)
						pending_results.push_back('{cur_fix.kind, PEN_NONE, BTN_NONE, 1'b0,
							'0, cur_fix.bad, i == cur_fix.cnt - 1});
				end else begin
					for (int i = 0; i < em_count; i++)
						pending_results.push_back(em_out[i]);
				end
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[1:0], m_tdata[3:2], m_tdata[4], m_tdata[14:5],
					m_tdata[15], m_tlast};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat at %0t: kind %0d tdata %h last %0d",
							$realtime, m_tuser, m_tdata, m_tlast);
				end else begin
					want = pending_results.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected kind %0d pen %0d btn %0d strip %0d code %0d bad %0d last %0d",
								want.kind, want.pen, want.btn, want.strip, want.code,
								want.bad, want.last);
							$display("  actual   kind %0d pen %0d btn %0d strip %0d code %0d bad %0d last %0d",
								got.kind, got.pen, got.btn, got.strip, got.code,
								got.bad, got.last);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_item(stim_t it, fixed_t fix);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, it.era_in, it.era_tog, it.pen_in, it.pen_tog};
		s_tuser <= it.cmd;
		cur_fix <= fix;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Hold off input until every outstanding result beat has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic en, logic [DELAY_W-1:0] dly, logic [CODE_W-1:0] code);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_ENABLE;
		cfg_data <= {19'b0, en};
		@(posedge clk);
		em_enable = en;
		cfg_index <= REG_DELAY;
		cfg_data <= dly;
		@(posedge clk);
		em_delay = dly;
		cfg_index <= REG_CODE;
		cfg_data <= {10'b0, code};
		@(posedge clk);
		em_code = code;
		// A write to the unused index must leave every register alone.
		cfg_index <= REG_SPARE;
		cfg_data <= 20'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_enable = en;
	endtask

	// Mostly tool moves that flip the current presence, plus ticks and arbitrary noise.
	function automatic stim_t next_stim();
		stim_t       it;
		int unsigned pick, tool;
		pick = $urandom_range(99);
		it = stim_t'({1'b0, 4'($urandom_range(15))});
		if (pick < 35) begin
			it.cmd = CMD_TICK;
		end else if (pick < 85) begin
			it = '0;
			tool = $urandom_range(4);
			if (tool <= 1 || tool == 4) begin
				it.pen_tog = 1'b1;
				it.pen_in = !gen_pen;
			end
			if (tool >= 2) begin
				it.era_tog = 1'b1;
				it.era_in = !gen_eraser;
			end
		end
		if (it.cmd == CMD_FRAME && gen_enable) begin
			if (it.pen_tog)
				gen_pen = it.pen_in;
			if (it.era_tog)
				gen_eraser = it.era_in;
		end
		return it;
	endfunction

	task automatic set_idling(int mode);
		send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 53 : 0;
		recv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 14 : 0;
	endtask

	initial begin
		int ph;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0);

		for (int r = 0; r < PLAN_DISABLED; r++)
			send_item(PLAN[r].s, PLAN[r].f);
		configure(1'b1, 20'd2, 10'd767);
		for (int r = PLAN_DISABLED; r < PLAN_LEN; r++)
			send_item(PLAN[r].s, PLAN[r].f);

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(1'b1, 20'd1, 10'd0);
				1: configure(1'b1, 20'($urandom_range(6, 2)), 10'($urandom_range(767)));
				2: configure(1'b0, 20'd3, 10'd767);
				3: configure(1'b1, 20'd1048575, 10'($urandom_range(767)));
				4: configure(1'b1, 20'($urandom_range(4, 1)), 10'($urandom_range(767)));
				default: configure(1'b1, 20'd2, CODE_RESET);
			endcase
			set_idling(ph / 2);
			for (int k = 0; k < 80; k++) begin
				if (k == 40)
					drain();
				send_item(next_stim(), NO_FIX);
			end
		end

		drain();
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ebe_pkg.sv
rtl/ebe_front.sv
rtl/ebe_queue.sv
rtl/ebe_back.sv
rtl/eraser_button_emulation.sv
tb/sv/eraser_button_emulation_tb.sv
